FILE: rtl/owsm_pkg.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer package
// Shared widths, defaults and reset values for the mixer and its interfaces.
// ----------------------------------------------------------------------------
package owsm_pkg;

    localparam int DEF_IN_WIDTH       = 16;
    localparam int DEF_COEF_FRAC_BITS = 14;

    localparam int LIMIT_W   = 8;
    localparam int MAG_OUT_W = 8;
    localparam int DIV_STEPS = MAG_OUT_W;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = LIMIT_W'(20);

endpackage

FILE: rtl/owsm_if.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer channels
// Motion command channel and wheel speed channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface owsm_cmd_if #(
    parameter int IN_WIDTH = owsm_pkg::DEF_IN_WIDTH
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] vel_x;
    logic signed [IN_WIDTH-1:0] vel_y;
    logic signed [IN_WIDTH-1:0] rot_rate;

    modport source (output valid, output vel_x, output vel_y, output rot_rate, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input rot_rate, output ready);
endinterface

interface owsm_spd_if;
    import owsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MAG_OUT_W-1:0] left_mag;
    logic                 left_rev;
    logic [MAG_OUT_W-1:0] right_mag;
    logic                 right_rev;
    logic [MAG_OUT_W-1:0] back_mag;
    logic                 back_rev;

    modport source (output valid, output left_mag, output left_rev, output right_mag,
                    output right_rev, output back_mag, output back_rev, input ready);
    modport sink   (input valid, input left_mag, input left_rev, input right_mag,
                    input right_rev, input back_mag, input back_rev, output ready);
endinterface

FILE: rtl/omni_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer
// Inverse kinematics for a three-wheel omni base: each motion command word is
// mixed into three wheel values, which are scaled so that the fastest wheel
// runs at the configured speed limit.
//
//   channel   direction   words
//   cmd       in          vel_x, vel_y, rot_rate
//   spd       out         left/right/back magnitude and reverse bit
//   cfg       in          speed_limit write (cfg_wr_en, cfg_wr_data)
//
// A word passes twelve register stages: one of coefficient products, one of
// wheel sums, one of magnitudes, one of peak and scaled numerators, and eight
// of a restoring divider, one quotient bit each. A new word can enter in every
// cycle while the output side takes words or a bubble is free. Each stage holds
// its word when the next one is full and stalled, so a stall fills bubbles
// first and drops nothing. Reset clears all valid bits and loads the speed
// limit with 20.
// ----------------------------------------------------------------------------
module omni_wheel_speed_mixer #(
    parameter int IN_WIDTH       = owsm_pkg::DEF_IN_WIDTH,
    parameter int COEF_FRAC_BITS = owsm_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    owsm_cmd_if.sink                      cmd,
    owsm_spd_if.source                    spd,
    input  logic                          cfg_wr_en,
    input  logic [owsm_pkg::LIMIT_W-1:0]  cfg_wr_data
);
    import owsm_pkg::*;

    localparam longint ONE_Q        = longint'(1) << COEF_FRAC_BITS;
    localparam longint THIRD_Q      = (ONE_Q + 1) / 3;
    localparam longint TWO_THIRDS_Q = (2 * ONE_Q + 1) / 3;
    localparam longint YCOEF_Q      = (25 * ONE_Q + 21) / 43;

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PW     = IN_WIDTH + COEF_W;
    localparam int SUM_W  = PW + 2;
    localparam int NW     = SUM_W + LIMIT_W;
    localparam int NST    = 4 + DIV_STEPS;

    localparam logic signed [COEF_W-1:0] C_THIRD      = COEF_W'(THIRD_Q);
    localparam logic signed [COEF_W-1:0] C_TWO_THIRDS = COEF_W'(TWO_THIRDS_Q);
    localparam logic signed [COEF_W-1:0] C_YCOEF      = COEF_W'(YCOEF_Q);

    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [NST-1:0]     vld_reg;
    logic [NST-1:0]     stage_en;

    logic signed [PW-1:0] prod_xt_reg, prod_yc_reg, prod_rt_reg, prod_x2_reg;
    logic signed [PW-1:0] prod_xt_next, prod_yc_next, prod_rt_next, prod_x2_next;

    logic signed [SUM_W-1:0] sum_reg [0:2];
    logic signed [SUM_W-1:0] sum_next [0:2];

    logic [SUM_W-1:0] mag_reg [0:2];
    logic [SUM_W-1:0] mag_next [0:2];
    logic [2:0]       neg_reg;

    logic [SUM_W-1:0] peak_next;

    logic [NW-1:0]        div_r_reg    [0:DIV_STEPS][0:2];
    logic [MAG_OUT_W-1:0] div_q_reg    [0:DIV_STEPS][0:2];
    logic [SUM_W-1:0]     div_peak_reg [0:DIV_STEPS];
    logic [2:0]           div_neg_reg  [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            speed_limit_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        stage_en[NST-1] = !vld_reg[NST-1] || spd.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign cmd.ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                vld_reg[0] <= cmd.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (stage_en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        prod_xt_next = PW'(cmd.vel_x) * PW'(C_THIRD);
        prod_yc_next = PW'(cmd.vel_y) * PW'(C_YCOEF);
        prod_rt_next = PW'(cmd.rot_rate) * PW'(C_THIRD);
        prod_x2_next = PW'(cmd.vel_x) * PW'(C_TWO_THIRDS);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            prod_xt_reg <= prod_xt_next;
            prod_yc_reg <= prod_yc_next;
            prod_rt_reg <= prod_rt_next;
            prod_x2_reg <= prod_x2_next;
        end
    end

    always_comb
    begin
        sum_next[0] = SUM_W'(prod_yc_reg) - SUM_W'(prod_xt_reg) + SUM_W'(prod_rt_reg);
        sum_next[1] = SUM_W'(prod_rt_reg) - SUM_W'(prod_xt_reg) - SUM_W'(prod_yc_reg);
        sum_next[2] = SUM_W'(prod_x2_reg) + SUM_W'(prod_rt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k] = sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k]) : SUM_W'(sum_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            mag_reg <= mag_next;
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= sum_reg[k][SUM_W-1];
            end
        end
    end

    always_comb
    begin
        peak_next = mag_reg[0];
        if (mag_reg[1] > peak_next)
        begin
            peak_next = mag_reg[1];
        end
        if (mag_reg[2] > peak_next)
        begin
            peak_next = mag_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                div_r_reg[0][k] <= NW'(mag_reg[k]) * NW'(speed_limit_reg);
                div_q_reg[0][k] <= '0;
            end
            div_peak_reg[0] <= peak_next;
            div_neg_reg[0]  <= neg_reg;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SHIFT = DIV_STEPS - 1 - j;

        logic [NW-1:0] dvs;
        logic [NW-1:0] r_next [0:2];
        logic [2:0]    q_bit;

        always_comb
        begin
            dvs = NW'(div_peak_reg[j]) << SHIFT;
            for (int k = 0; k < 3; k++)
            begin
                q_bit[k]  = (div_peak_reg[j] != '0) && (div_r_reg[j][k] >= dvs);
                r_next[k] = q_bit[k] ? div_r_reg[j][k] - dvs : div_r_reg[j][k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[4+j])
            begin
                for (int k = 0; k < 3; k++)
                begin
                    div_r_reg[j+1][k] <= r_next[k];
                    div_q_reg[j+1][k] <= {div_q_reg[j][k][MAG_OUT_W-2:0], q_bit[k]};
                end
                div_peak_reg[j+1] <= div_peak_reg[j];
                div_neg_reg[j+1]  <= div_neg_reg[j];
            end
        end
    end

    assign spd.valid     = vld_reg[NST-1];
    assign spd.left_mag  = div_q_reg[DIV_STEPS][0];
    assign spd.right_mag = div_q_reg[DIV_STEPS][1];
    assign spd.back_mag  = div_q_reg[DIV_STEPS][2];
    assign spd.left_rev  = div_neg_reg[DIV_STEPS][0];
    assign spd.right_rev = div_neg_reg[DIV_STEPS][1];
    assign spd.back_rev  = div_neg_reg[DIV_STEPS][2];

    // No wheel may run faster than the configured limit.
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        spd.valid |-> (spd.left_mag <= speed_limit_reg) && (spd.right_mag <= speed_limit_reg)
                      && (spd.back_mag <= speed_limit_reg))
        else $error("wheel magnitude above speed limit");

    // When any wheel moves, the fastest one runs exactly at the limit.
    a_peak_hits_limit: assert property (@(posedge clk) disable iff (!rst_n)
        spd.valid && ((spd.left_mag | spd.right_mag | spd.back_mag) != '0)
        |-> (spd.left_mag == speed_limit_reg) || (spd.right_mag == speed_limit_reg)
            || (spd.back_mag == speed_limit_reg))
        else $error("fastest wheel not at speed limit");

    // A free output side never back-pressures the command side.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        spd.ready |-> cmd.ready)
        else $error("command stalled while output is free");

endmodule

FILE: bench/omni_wheel_speed_mixer_tb.sv
// ----------------------------------------------------------------------------
// Omni wheel speed mixer testbench
// Drives motion command words into the mixer and checks every wheel speed
// word against a fixed-point inverse kinematics predictor in the bench.
// Directed words cover the zero vector, the field extremes, tiny reverse
// wheels and the speed limit extremes. Random phases at several limits
// follow, with random idling on both channels in all but one of them.
// ----------------------------------------------------------------------------
module omni_wheel_speed_mixer_tb;
    import owsm_pkg::*;

    localparam int IN_W      = DEF_IN_WIDTH;
    localparam int FRAC_BITS = DEF_COEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_MARGIN = 16;

    localparam longint ONE_Q           = 64'sd1 <<< FRAC_BITS;
    localparam longint COEF_THIRD      = (ONE_Q + 1) / 3;
    localparam longint COEF_TWO_THIRDS = (2 * ONE_Q + 1) / 3;
    localparam longint COEF_FWD        = (25 * ONE_Q + 21) / 43;

    localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};

    typedef logic signed [IN_W-1:0] vel_t;

    typedef struct packed {
        logic [MAG_OUT_W-1:0] left_mag;
        logic                 left_rev;
        logic [MAG_OUT_W-1:0] right_mag;
        logic                 right_rev;
        logic [MAG_OUT_W-1:0] back_mag;
        logic                 back_rev;
    } wheel_speeds_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    owsm_cmd_if #(.IN_WIDTH(IN_W)) cmd();
    owsm_spd_if                    spd();

    omni_wheel_speed_mixer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .spd         (spd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    wheel_speeds_t      pending_speeds[$];
    logic [LIMIT_W-1:0] limit_now = SPEED_LIMIT_RESET;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 src_idle_pct = 16;
    int                 snk_idle_pct = 16;

    function automatic wheel_speeds_t mix_wheels(input vel_t x, input vel_t y, input vel_t r,
                                                 input logic [LIMIT_W-1:0] lim);
        longint          wsum[3];
        longint unsigned wabs[3];
        longint unsigned peak;
        longint unsigned scaled[3];
        logic            rev[3];
        wheel_speeds_t   w;
        wsum[0] = -COEF_THIRD * x + COEF_FWD * y + COEF_THIRD * r;
        wsum[1] = -COEF_THIRD * x - COEF_FWD * y + COEF_THIRD * r;
        wsum[2] = COEF_TWO_THIRDS * x + COEF_THIRD * r;
        peak = 0;
        for (int k = 0; k < 3; k++)
        begin
            wabs[k] = (wsum[k] < 0) ? longint'(-wsum[k]) : longint'(wsum[k]);
            if (wabs[k] > peak)
                peak = wabs[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            scaled[k] = 0;
            rev[k] = 1'b0;
            if (peak != 0)
            begin
                scaled[k] = (wabs[k] * longint'(lim)) / peak;
                rev[k] = (wsum[k] < 0);
            end
        end
        w.left_mag  = scaled[0][MAG_OUT_W-1:0];
        w.left_rev  = rev[0];
        w.right_mag = scaled[1][MAG_OUT_W-1:0];
        w.right_rev = rev[1];
        w.back_mag  = scaled[2][MAG_OUT_W-1:0];
        w.back_rev  = rev[2];
        return w;
    endfunction

    function automatic vel_t rand_vel();
        vel_t v;
        case ($urandom_range(4))
            0: v = vel_t'($urandom_range(64)) - vel_t'(32);
            1:
            begin
                case ($urandom_range(4))
                    0: v = IN_MAX;
                    1: v = IN_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = vel_t'(1);
                endcase
            end
            default: v = vel_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
        error_count++;
    endtask

    task automatic send_word(input vel_t x, input vel_t y, input vel_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.vel_x    <= x;
        cmd.vel_y    <= y;
        cmd.rot_rate <= r;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        pending_speeds.push_back(mix_wheels(x, y, r, limit_now));
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_speeds.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_speed_limit(input logic [LIMIT_W-1:0] lim);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_now = lim;
    endtask

    task automatic test_zero_vector();
        send_word('0, '0, '0);
    endtask

    task automatic test_field_extremes();
        send_word(IN_MAX, '0, '0);
        send_word(IN_MIN, '0, '0);
        send_word('0, IN_MAX, '0);
        send_word('0, IN_MIN, '0);
        send_word('0, '0, IN_MAX);
        send_word('0, '0, IN_MIN);
        send_word(IN_MAX, IN_MAX, IN_MAX);
        send_word(IN_MIN, IN_MIN, IN_MIN);
        send_word('1, '1, '1);
        send_word(IN_MAX, IN_MIN, IN_MAX);
    endtask

    task automatic test_tiny_reverse();
        send_word('0, IN_MAX, '1);
        send_word('0, IN_MIN, vel_t'(1));
        send_word(vel_t'(1), IN_MAX, '0);
    endtask

    task automatic test_zero_limit();
        set_speed_limit('0);
        send_word(IN_MAX, IN_MIN, IN_MAX);
        send_word('0, IN_MAX, '1);
        send_word('0, '0, '0);
    endtask

    task automatic test_full_limit();
        set_speed_limit('1);
        send_word(IN_MIN, IN_MAX, IN_MIN);
        send_word('0, '0, IN_MAX);
        send_word('0, IN_MIN, vel_t'(1));
        send_word(vel_t'(5), vel_t'(-3), vel_t'(2));
    endtask

    task automatic test_random_mix(input int count, input logic [LIMIT_W-1:0] lim,
                                   input int idle_pct);
        set_speed_limit(lim);
        src_idle_pct = idle_pct;
        snk_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
            send_word(rand_vel(), rand_vel(), rand_vel());
        drain();
        src_idle_pct = 16;
        snk_idle_pct = 16;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        spd.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            spd.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        wheel_speeds_t want;
        forever
        begin
            @(posedge clk);
            if (spd.valid === 1'b1 && spd.ready === 1'b1)
            begin
                if (pending_speeds.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    want = pending_speeds.pop_front();
                    if (spd.left_mag !== want.left_mag)
                        report_mismatch("left_mag", spd.left_mag, want.left_mag);
                    if (spd.left_rev !== want.left_rev)
                        report_mismatch("left_rev", spd.left_rev, want.left_rev);
                    if (spd.right_mag !== want.right_mag)
                        report_mismatch("right_mag", spd.right_mag, want.right_mag);
                    if (spd.right_rev !== want.right_rev)
                        report_mismatch("right_rev", spd.right_rev, want.right_rev);
                    if (spd.back_mag !== want.back_mag)
                        report_mismatch("back_mag", spd.back_mag, want.back_mag);
                    if (spd.back_rev !== want.back_rev)
                        report_mismatch("back_rev", spd.back_rev, want.back_rev);
                end
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        cmd.valid    <= 1'b0;
        cmd.vel_x    <= '0;
        cmd.vel_y    <= '0;
        cmd.rot_rate <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_vector();
        test_field_extremes();
        test_tiny_reverse();
        test_zero_limit();
        test_full_limit();
        test_random_mix(300, 8'd255, 16);
        test_random_mix(300, 8'd1, 16);
        test_random_mix(300, LIMIT_W'($urandom), 0);
        test_random_mix(300, LIMIT_W'($urandom), 16);
        test_random_mix(300, 8'd128, 16);
        test_random_mix(200, LIMIT_W'($urandom), 16);
        test_random_mix(100, 8'd0, 16);

        drain();
        repeat (DRAIN_MARGIN) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/owsm_pkg.sv
rtl/owsm_if.sv
rtl/omni_wheel_speed_mixer.sv
bench/omni_wheel_speed_mixer_tb.sv
